### src/tlqs_pkg.sv
// Package of shared types and codes for the three-level queue scheduler.
`timescale 1ns / 1ps
package tlqs_pkg;

   typedef enum logic [1:0] {
      REQ_ENQUEUE  = 2'd0,
      REQ_DEQUEUE  = 2'd1,
      REQ_REQUEUE  = 2'd2,
      REQ_RESERVED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   localparam logic [1:0] LVL_NONE   = 2'd0;
   localparam logic [1:0] LVL_HIGH   = 2'd1;
   localparam logic [1:0] LVL_NORMAL = 2'd2;
   localparam logic [1:0] LVL_LOW    = 2'd3;

   localparam logic [1:0] PRIO_HIGH   = 2'd1;
   localparam logic [1:0] PRIO_NORMAL = 2'd2;
   localparam logic [1:0] PRIO_LOW    = 2'd3;

   localparam int NUM_QUEUES = 3;
   localparam int Q_HIGH     = 0;
   localparam int Q_NORMAL   = 1;
   localparam int Q_LOW      = 2;

   // Occupancy flags of the three rings, bit 0 is the high queue.
   typedef struct packed {
      logic [NUM_QUEUES-1:0] full;
      logic [NUM_QUEUES-1:0] empty;
   } qstat_type;

   // One-hot push and pop strobes towards the rings.
   typedef struct packed {
      logic [NUM_QUEUES-1:0] push;
      logic [NUM_QUEUES-1:0] pop;
   } qcmd_type;

endpackage

### src/tlqs_ring.sv
// Ring buffer of process ids with head pointer, fill count and registered read.
`timescale 1ns / 1ps
module tlqs_ring #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       pop,
   input  logic [7:0] push_id,
   output logic       full,
   output logic       empty,
   output logic [7:0] rd_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    mem [DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    rd_data_ff;
   logic [CW:0]   tail_sum;
   logic [PW-1:0] tail;

   // Wrap head plus count back into the ring.
   always_comb begin
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(DEPTH);
      end
      tail = tail_sum[PW-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CW'(1);
      end else if (pop) begin
         count_in = count_ff - CW'(1);
         if (head_ff == PW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= push_id;
      end
      if (pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = rd_data_ff;

endmodule

### src/tlqs_ctrl.sv
// Request decoder: picks the queue, the push or pop strobe and the status.
`timescale 1ns / 1ps
module tlqs_ctrl (
   input  logic [1:0]         req_type,
   input  logic [1:0]         priority_req,
   input  logic               still_running,
   input  tlqs_pkg::qstat_type qstat,
   output tlqs_pkg::qcmd_type  qcmd,
   output logic [1:0]         status,
   output logic [1:0]         level,
   output logic               is_deq
);
   import tlqs_pkg::*;

   always_comb begin
      qcmd   = '0;
      status = ST_IGNORED;
      level  = LVL_NONE;
      is_deq = 1'b0;
      case (req_type)
         REQ_ENQUEUE: begin
            if (priority_req == PRIO_HIGH && !qstat.full[Q_HIGH]) begin
               qcmd.push[Q_HIGH] = 1'b1;
               status            = ST_DONE;
               level             = LVL_HIGH;
            end else if (priority_req == PRIO_NORMAL && !qstat.full[Q_NORMAL]) begin
               qcmd.push[Q_NORMAL] = 1'b1;
               status              = ST_DONE;
               level               = LVL_NORMAL;
            end else if (!qstat.full[Q_LOW]) begin
               qcmd.push[Q_LOW] = 1'b1;
               status           = ST_DONE;
               level            = LVL_LOW;
            end else begin
               status = ST_FULL;
            end
         end
         REQ_DEQUEUE: begin
            is_deq = 1'b1;
            if (!qstat.empty[Q_HIGH]) begin
               qcmd.pop[Q_HIGH] = 1'b1;
               status           = ST_DONE;
               level            = LVL_HIGH;
            end else if (!qstat.empty[Q_NORMAL]) begin
               qcmd.pop[Q_NORMAL] = 1'b1;
               status             = ST_DONE;
               level              = LVL_NORMAL;
            end else if (!qstat.empty[Q_LOW]) begin
               qcmd.pop[Q_LOW] = 1'b1;
               status          = ST_DONE;
               level           = LVL_LOW;
            end else begin
               status = ST_EMPTY;
            end
         end
         REQ_REQUEUE: begin
            if (still_running && (priority_req inside {PRIO_NORMAL, PRIO_LOW})) begin
               if (priority_req == PRIO_NORMAL) begin
                  if (qstat.full[Q_NORMAL]) begin
                     status = ST_FULL;
                  end else begin
                     qcmd.push[Q_NORMAL] = 1'b1;
                     status              = ST_DONE;
                     level               = LVL_NORMAL;
                  end
               end else begin
                  if (qstat.full[Q_LOW]) begin
                     status = ST_FULL;
                  end else begin
                     qcmd.push[Q_LOW] = 1'b1;
                     status           = ST_DONE;
                     level            = LVL_LOW;
                  end
               end
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
   end

endmodule

### src/three_level_queue_scheduler.sv
// Top level of the three-level queue scheduler: request register, rings, result register.
// Path: an accepted request word goes through the request register to the result register.
// Throughput: one request word per cycle while rsp_stall is low, set by the single pass
//   through the decoder and the one push or pop that each ring performs per cycle.
// Reset: synchronous, active high; empties all three queues and drops any held word.
// Queue contents are not cleared; the fill counts guard every read.
`timescale 1ns / 1ps
module three_level_queue_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_proc_id,
   input  logic [1:0] req_priority_req,
   input  logic       req_still_running,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_level,
   output logic [7:0] rsp_out_proc_id
);
   import tlqs_pkg::*;

   // Request register: hold the accepted word until the result stage can take it.
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_type_ff;
   logic [7:0] s1_id_ff;
   logic [1:0] s1_prio_ff;
   logic       s1_run_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff;
   logic [1:0] rsp_level_ff;
   logic       rsp_deq_ff;

   logic       req_accept;
   logic       advance;

   qstat_type  qstat;
   qcmd_type   qcmd;
   qcmd_type   qcmd_gated;
   logic [1:0] dec_status;
   logic [1:0] dec_level;
   logic       dec_is_deq;
   logic [7:0] rd_data [NUM_QUEUES];

   // Advance the request word whenever the result register is free or being drained.
   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff <= req_type;
         s1_id_ff   <= req_proc_id;
         s1_prio_ff <= req_priority_req;
         s1_run_ff  <= req_still_running;
      end
      if (advance) begin
         rsp_status_ff <= dec_status;
         rsp_level_ff  <= dec_level;
         rsp_deq_ff    <= dec_is_deq;
      end
   end

   tlqs_ctrl u_ctrl (
      .req_type      (s1_type_ff),
      .priority_req  (s1_prio_ff),
      .still_running (s1_run_ff),
      .qstat         (qstat),
      .qcmd          (qcmd),
      .status        (dec_status),
      .level         (dec_level),
      .is_deq        (dec_is_deq)
   );

   // Commit the queue update only on the edge the word moves to the result register.
   assign qcmd_gated = advance ? qcmd : '0;

   // One ring per level; a popped head lands in the ring's read register
   // on the same edge the result word is loaded.
   for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_ring
      tlqs_ring #(
         .DEPTH (QUEUE_DEPTH)
      ) u_ring (
         .clock   (clock),
         .reset   (reset),
         .push    (qcmd_gated.push[q]),
         .pop     (qcmd_gated.pop[q]),
         .push_id (s1_id_ff),
         .full    (qstat.full[q]),
         .empty   (qstat.empty[q]),
         .rd_data (rd_data[q])
      );
   end

   // Select the popped id by level; drive zero for anything but a successful dequeue.
   always_comb begin
      rsp_out_proc_id = 8'd0;
      if (rsp_deq_ff) begin
         case (rsp_level_ff)
            LVL_HIGH:   rsp_out_proc_id = rd_data[Q_HIGH];
            LVL_NORMAL: rsp_out_proc_id = rd_data[Q_NORMAL];
            LVL_LOW:    rsp_out_proc_id = rd_data[Q_LOW];
            default:    rsp_out_proc_id = 8'd0;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_level  = rsp_level_ff;

endmodule

### tb/sv/three_level_queue_scheduler_test.sv
// Self-checking testbench of the three-level queue scheduler with its own queue predictor.
`timescale 1ns / 1ps
module three_level_queue_scheduler_test;
   import tlqs_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int WORD_TARGET = 850;
   localparam int SHOW_LIMIT  = 10;

   // One request word as the sender offers it.
   typedef struct {
      req_code_type kind;
      logic [7:0]   id;
      logic [1:0]   prio;
      logic         running;
   } req_word_type;

   // One result word as the scheduler should answer it.
   typedef struct {
      status_type status;
      logic [1:0] level;
      logic [7:0] id;
   } sched_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_type;
   logic [7:0] req_proc_id;
   logic [1:0] req_priority_req;
   logic       req_still_running;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [1:0] rsp_level;
   logic [7:0] rsp_out_proc_id;

   // Predictor state: three rings with their heads and fill counts.
   logic [7:0] ring_mem [NUM_QUEUES][DEPTH];
   int         ring_fill [NUM_QUEUES];
   int         ring_head [NUM_QUEUES];

   req_word_type     pending_words [$];
   sched_result_type due_results [$];

   req_word_type     next_word;
   req_word_type     seen_word;
   sched_result_type got;
   sched_result_type want;

   bit req_taken;
   bit held_once;
   int hold_left;
   int n_taken;
   int n_results;
   int cycle_count;
   int mismatch_count;

   // No idling on either side while this window of words passes.
   logic calm_stretch;
   assign calm_stretch = (n_taken >= 450) && (n_taken < 600);

   three_level_queue_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_proc_id       (req_proc_id),
      .req_priority_req  (req_priority_req),
      .req_still_running (req_still_running),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_level         (rsp_level),
      .rsp_out_proc_id   (rsp_out_proc_id)
   );

   always #5 clock = ~clock;

   // Map a ring index onto the level code reported in the result word.
   function automatic logic [1:0] level_code(int q);
      case (q)
         Q_HIGH:   return LVL_HIGH;
         Q_NORMAL: return LVL_NORMAL;
         default:  return LVL_LOW;
      endcase
   endfunction

   // Append an id to the tail of one ring; refuse it when the ring is full.
   function automatic bit ring_push(int q, logic [7:0] id);
      if (ring_fill[q] >= DEPTH) return 1'b0;
      ring_mem[q][(ring_head[q] + ring_fill[q]) % DEPTH] = id;
      ring_fill[q] = ring_fill[q] + 1;
      return 1'b1;
   endfunction

   // Apply one request to the predicted rings and return the answer it earns.
   function automatic sched_result_type schedule_word(req_word_type w);
      sched_result_type r;
      int               q;
      bit               found;
      r.status = ST_IGNORED;
      r.level  = LVL_NONE;
      r.id     = 8'd0;
      found    = 1'b0;
      case (w.kind)
         REQ_ENQUEUE: begin
            // A full high or normal ring spills into the low ring.
            if (w.prio == PRIO_HIGH && ring_push(Q_HIGH, w.id)) q = Q_HIGH;
            else if (w.prio == PRIO_NORMAL && ring_push(Q_NORMAL, w.id)) q = Q_NORMAL;
            else if (ring_push(Q_LOW, w.id)) q = Q_LOW;
            else q = -1;
            if (q < 0) begin
               r.status = ST_FULL;
            end else begin
               r.status = ST_DONE;
               r.level  = level_code(q);
            end
         end
         REQ_DEQUEUE: begin
            r.status = ST_EMPTY;
            for (int i = 0; i < NUM_QUEUES; i++) begin
               if (!found && ring_fill[i] != 0) begin
                  r.id         = ring_mem[i][ring_head[i]];
                  ring_head[i] = (ring_head[i] + 1) % DEPTH;
                  ring_fill[i] = ring_fill[i] - 1;
                  r.status     = ST_DONE;
                  r.level      = level_code(i);
                  found        = 1'b1;
               end
            end
         end
         REQ_REQUEUE: begin
            // Only a running normal or low process goes back, and only to its own ring.
            if (w.running && (w.prio == PRIO_NORMAL || w.prio == PRIO_LOW)) begin
               q = (w.prio == PRIO_NORMAL) ? Q_NORMAL : Q_LOW;
               if (ring_push(q, w.id)) begin
                  r.status = ST_DONE;
                  r.level  = level_code(q);
               end else begin
                  r.status = ST_FULL;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_failure(string what);
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT) $display("%0t: %s", $time, what);
   endtask

   task automatic add_word(req_code_type kind, logic [7:0] id, logic [1:0] prio,
                           logic running);
      req_word_type w;
      w.kind    = kind;
      w.id      = id;
      w.prio    = prio;
      w.running = running;
      pending_words.push_back(w);
   endtask

   // Driver: offer a new word at the falling edge once the last one was taken.
   // Hold the payload while it is stalled; the idle choice never looks at stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0 && (calm_stretch || $urandom_range(99) >= 33)) begin
            next_word = pending_words.pop_front();
            req_valid         <= 1'b1;
            req_type          <= next_word.kind;
            req_proc_id       <= next_word.id;
            req_priority_req  <= next_word.prio;
            req_still_running <= next_word.running;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: random idling, plus one long hold-off that backs the
   // block up until it stalls its own input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!held_once && n_taken >= 300) begin
         held_once <= 1'b1;
         hold_left <= 80;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm_stretch && ($urandom_range(99) < 33);
      end
   end

   // Monitor: predict each accepted request word, then check each accepted
   // result word against the oldest prediction.
   always @(posedge clock) begin
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_word.kind    = req_code_type'(req_type);
            seen_word.id      = req_proc_id;
            seen_word.prio    = req_priority_req;
            seen_word.running = req_still_running;
            due_results.push_back(schedule_word(seen_word));
            req_taken = 1'b1;
            n_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            got.status = status_type'(rsp_status);
            got.level  = rsp_level;
            got.id     = rsp_out_proc_id;
            if (due_results.size() == 0) begin
               flag_failure($sformatf("result word %0d arrived with nothing expected",
                                      n_results));
            end else begin
               want = due_results.pop_front();
               if (got.status !== want.status || got.level !== want.level ||
                   got.id !== want.id)
                  flag_failure($sformatf(
                     "result word %0d: expected status %0d level %0d id %0d, got %0d %0d %0d",
                     n_results, want.status, want.level, want.id,
                     rsp_status, rsp_level, rsp_out_proc_id));
            end
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int           burst_mode;
      int           burst_len;
      int           roll;
      int           counted;
      logic [1:0]   favour;
      logic [1:0]   prio;
      req_code_type kind;

      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = REQ_ENQUEUE;
      req_proc_id       = 8'd0;
      req_priority_req  = PRIO_HIGH;
      req_still_running = 1'b0;
      rsp_stall         = 1'b0;
      req_taken         = 1'b0;
      held_once         = 1'b0;
      hold_left         = 0;
      n_taken           = 0;
      n_results         = 0;
      cycle_count       = 0;
      mismatch_count    = 0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         ring_fill[i] = 0;
         ring_head[i] = 0;
      end

      // Directed words: empty dequeue, every priority on enqueue, requeues refused for their
      // priority or a stopped process and requeues taken, the reserved request, then a full drain.
      add_word(REQ_DEQUEUE, 8'h00, PRIO_HIGH, 1'b0);
      add_word(REQ_ENQUEUE, 8'h00, PRIO_HIGH, 1'b0);
      add_word(REQ_ENQUEUE, 8'hFF, PRIO_NORMAL, 1'b1);
      add_word(REQ_ENQUEUE, 8'h5A, PRIO_LOW, 1'b0);
      add_word(REQ_ENQUEUE, 8'hA5, 2'd0, 1'b1);
      add_word(REQ_REQUEUE, 8'h11, PRIO_HIGH, 1'b1);
      add_word(REQ_REQUEUE, 8'h22, 2'd0, 1'b1);
      add_word(REQ_REQUEUE, 8'h44, PRIO_NORMAL, 1'b0);
      add_word(REQ_REQUEUE, 8'h33, PRIO_NORMAL, 1'b1);
      add_word(REQ_REQUEUE, 8'hCC, PRIO_LOW, 1'b1);
      add_word(REQ_RESERVED, 8'hFF, PRIO_LOW, 1'b1);
      repeat (7) add_word(REQ_DEQUEUE, 8'hFF, PRIO_LOW, 1'b1);

      // Random bursts: fill bursts drive rings to full and overflow, drain
      // bursts empty them again, mixed bursts interleave both.
      counted = 0;
      while (counted < WORD_TARGET) begin
         burst_mode = $urandom_range(2);
         burst_len  = $urandom_range(40, 8);
         favour     = 2'($urandom_range(3, 1));
         repeat (burst_len) begin
            roll = $urandom_range(99);
            case (burst_mode)
               0:       kind = roll < 75 ? REQ_ENQUEUE : roll < 90 ? REQ_REQUEUE :
                               roll < 97 ? REQ_DEQUEUE : REQ_RESERVED;
               1:       kind = roll < 70 ? REQ_DEQUEUE : roll < 85 ? REQ_ENQUEUE :
                               roll < 97 ? REQ_REQUEUE : REQ_RESERVED;
               default: kind = roll < 40 ? REQ_ENQUEUE : roll < 75 ? REQ_DEQUEUE :
                               roll < 95 ? REQ_REQUEUE : REQ_RESERVED;
            endcase
            prio = ($urandom_range(99) < 70) ? favour : 2'($urandom_range(3));
            add_word(kind, 8'($urandom_range(255)), prio, $urandom_range(99) < 80);
            if (kind != REQ_RESERVED) counted++;
         end
      end

      // Release reset at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every word offered and taken, every result back, then a few
      // quiet cycles to catch stray result words.
      while (pending_words.size() != 0 || (req_valid && !req_taken)) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
src/tlqs_pkg.sv
src/tlqs_ring.sv
src/tlqs_ctrl.sv
src/three_level_queue_scheduler.sv
tb/sv/three_level_queue_scheduler_test.sv
